/* rtl/sha_pkg.sv */
// ----------------------------------------------------------------------------
// sha_pkg
// shared types, constants and round functions for the streaming sha-256 hasher
// ----------------------------------------------------------------------------
package sha_pkg;

	localparam int unsigned QueueDepth = 4;
	localparam int unsigned BlockWords = 16;
	localparam int unsigned Rounds = 64;
	localparam int unsigned DigestWords = 8;
	localparam logic [7:0] PadByte = 8'h80;
	localparam logic [5:0] LengthPos = 6'd56;

	typedef logic [31:0] word_t;
	typedef word_t [7:0] hash_t;

	// word handed from the front end to the compression engine
	typedef struct packed {
		word_t	word;
		logic	blk_last;	// closes a 64-byte block
		logic	msg_last;	// closes the final block of a message
	} queue_item_t;

	localparam hash_t InitHash = {
		32'h5BE0CD19, 32'h1F83D9AB, 32'h9B05688C, 32'h510E527F,
		32'hA54FF53A, 32'h3C6EF372, 32'hBB67AE85, 32'h6A09E667
	};

	function automatic word_t round_const(input logic [5:0] t);
		word_t k;
		case (t)
			6'd0: k = 32'h428A2F98; 6'd1: k = 32'h71374491; 6'd2: k = 32'hB5C0FBCF;
			6'd3: k = 32'hE9B5DBA5; 6'd4: k = 32'h3956C25B; 6'd5: k = 32'h59F111F1;
			6'd6: k = 32'h923F82A4; 6'd7: k = 32'hAB1C5ED5; 6'd8: k = 32'hD807AA98;
			6'd9: k = 32'h12835B01; 6'd10: k = 32'h243185BE; 6'd11: k = 32'h550C7DC3;
			6'd12: k = 32'h72BE5D74; 6'd13: k = 32'h80DEB1FE; 6'd14: k = 32'h9BDC06A7;
			6'd15: k = 32'hC19BF174; 6'd16: k = 32'hE49B69C1; 6'd17: k = 32'hEFBE4786;
			6'd18: k = 32'h0FC19DC6; 6'd19: k = 32'h240CA1CC; 6'd20: k = 32'h2DE92C6F;
			6'd21: k = 32'h4A7484AA; 6'd22: k = 32'h5CB0A9DC; 6'd23: k = 32'h76F988DA;
			6'd24: k = 32'h983E5152; 6'd25: k = 32'hA831C66D; 6'd26: k = 32'hB00327C8;
			6'd27: k = 32'hBF597FC7; 6'd28: k = 32'hC6E00BF3; 6'd29: k = 32'hD5A79147;
			6'd30: k = 32'h06CA6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27B70A85;
			6'd33: k = 32'h2E1B2138; 6'd34: k = 32'h4D2C6DFC; 6'd35: k = 32'h53380D13;
			6'd36: k = 32'h650A7354; 6'd37: k = 32'h766A0ABB; 6'd38: k = 32'h81C2C92E;
			6'd39: k = 32'h92722C85; 6'd40: k = 32'hA2BFE8A1; 6'd41: k = 32'hA81A664B;
			6'd42: k = 32'hC24B8B70; 6'd43: k = 32'hC76C51A3; 6'd44: k = 32'hD192E819;
			6'd45: k = 32'hD6990624; 6'd46: k = 32'hF40E3585; 6'd47: k = 32'h106AA070;
			6'd48: k = 32'h19A4C116; 6'd49: k = 32'h1E376C08; 6'd50: k = 32'h2748774C;
			6'd51: k = 32'h34B0BCB5; 6'd52: k = 32'h391C0CB3; 6'd53: k = 32'h4ED8AA4A;
			6'd54: k = 32'h5B9CCA4F; 6'd55: k = 32'h682E6FF3; 6'd56: k = 32'h748F82EE;
			6'd57: k = 32'h78A5636F; 6'd58: k = 32'h84C87814; 6'd59: k = 32'h8CC70208;
			6'd60: k = 32'h90BEFFFA; 6'd61: k = 32'hA4506CEB; 6'd62: k = 32'hBEF9A3F7;
			default: k = 32'hC67178F2;
		endcase
		return k;
	endfunction

	function automatic word_t rotr(input word_t x, input int unsigned n);
		return (x >> n) | (x << (32 - n));
	endfunction

	function automatic word_t sig0(input word_t x);
		return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
	endfunction

	function automatic word_t sig1(input word_t x);
		return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
	endfunction

	function automatic word_t bsig0(input word_t x);
		return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
	endfunction

	function automatic word_t bsig1(input word_t x);
		return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
	endfunction

endpackage

/* rtl/sha_in_if.sv */
// ----------------------------------------------------------------------------
// sha_in_if
// byte request channel into the hasher
// ----------------------------------------------------------------------------
interface sha_in_if;
	logic		valid;
	logic		ready;
	logic		has_byte;
	logic [7:0]	data_byte;
	logic		end_of_message;

	modport source (output valid, has_byte, data_byte, end_of_message, input ready);
	modport sink (input valid, has_byte, data_byte, end_of_message, output ready);
endinterface

/* rtl/sha_out_if.sv */
// ----------------------------------------------------------------------------
// sha_out_if
// digest word channel out of the hasher
// ----------------------------------------------------------------------------
interface sha_out_if;
	logic		valid;
	logic		ready;
	logic [31:0]	digest_word;
	logic [2:0]	word_index;
	logic		last_word;

	modport source (output valid, digest_word, word_index, last_word, input ready);
	modport sink (input valid, digest_word, word_index, last_word, output ready);
endinterface

/* rtl/sha_front.sv */
// ----------------------------------------------------------------------------
// sha_front
// packs bytes into big-endian words, counts length, emits padding words
// ----------------------------------------------------------------------------
module sha_front (
	input  logic			clk,
	input  logic			arst_n,
	input  logic			in_valid,
	output logic			in_ready,
	input  logic			has_byte,
	input  logic [7:0]		data_byte,
	input  logic			end_of_message,
	output logic			q_valid,
	input  logic			q_ready,
	output sha_pkg::queue_item_t	q_item
);
	typedef enum logic [1:0] {ST_BYTES, ST_PAD, ST_LEN_HI, ST_LEN_LO} state_t;

	state_t		state_q;
	logic [5:0]	fill_q;		// bytes taken into the current block
	logic [63:0]	bits_q;
	logic [23:0]	part_q;		// bytes of the word being packed
	logic		pad_done_q;	// 0x80 already placed

	logic [31:0]	word_full;
	logic [31:0]	pad_word;
	logic [1:0]	bpos;

	assign bpos = fill_q[1:0];

	always_comb begin
		case (bpos)
			2'd0: word_full = {data_byte, 24'h0};
			2'd1: word_full = {part_q[23:16], data_byte, 16'h0};
			2'd2: word_full = {part_q[23:8], data_byte, 8'h0};
			default: word_full = {part_q, data_byte};
		endcase
	end

	// first padding word carries the pad byte after any partial bytes
	always_comb begin
		if (pad_done_q) begin
			pad_word = '0;
		end else begin
			case (bpos)
				2'd0: pad_word = {sha_pkg::PadByte, 24'h0};
				2'd1: pad_word = {part_q[23:16], sha_pkg::PadByte, 16'h0};
				2'd2: pad_word = {part_q[23:8], sha_pkg::PadByte, 8'h0};
				default: pad_word = {part_q, sha_pkg::PadByte};
			endcase
		end
	end

	always_comb begin
		q_valid = 1'b0;
		q_item = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_BYTES: begin
				in_ready = q_ready || !has_byte || (bpos != 2'd3);
				q_valid = in_valid && has_byte && (bpos == 2'd3);
				q_item.word = word_full;
				q_item.blk_last = (fill_q == 6'd63);
			end
			ST_PAD: begin
				q_valid = 1'b1;
				q_item.word = pad_word;
				q_item.blk_last = (fill_q[5:2] == 4'hF);
			end
			ST_LEN_HI: begin
				q_valid = 1'b1;
				q_item.word = bits_q[63:32];
			end
			default: begin
				q_valid = 1'b1;
				q_item.word = bits_q[31:0];
				q_item.blk_last = 1'b1;
				q_item.msg_last = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_BYTES;
			fill_q <= '0;
			bits_q <= '0;
			part_q <= '0;
			pad_done_q <= 1'b0;
		end else begin
			case (state_q)
				ST_BYTES: begin
					if (in_valid && in_ready) begin
						if (has_byte) begin
							fill_q <= fill_q + 6'd1;
							bits_q <= bits_q + 64'd8;
							case (bpos)
								2'd0: part_q[23:16] <= data_byte;
								2'd1: part_q[15:8] <= data_byte;
								2'd2: part_q[7:0] <= data_byte;
								default: part_q <= part_q;
							endcase
						end
						if (end_of_message) begin
							state_q <= ST_PAD;
							pad_done_q <= 1'b0;
						end
					end
				end
				ST_PAD: begin
					if (q_ready) begin
						// align to the next word, then go on to the length words
						fill_q <= {fill_q[5:2] + 4'd1, 2'b00};
						pad_done_q <= 1'b1;
						if (fill_q[5:2] == 4'd13) state_q <= ST_LEN_HI;
						part_q <= '0;
					end
				end
				ST_LEN_HI: begin
					if (q_ready) state_q <= ST_LEN_LO;
				end
				default: begin
					if (q_ready) begin
						state_q <= ST_BYTES;
						fill_q <= '0;
						bits_q <= '0;
					end
				end
			endcase
		end
	end
endmodule

/* rtl/sha_queue.sv */
// ----------------------------------------------------------------------------
// sha_queue
// small word queue between the front end and the compression engine
// ----------------------------------------------------------------------------
module sha_queue #(
	parameter int unsigned DEPTH = sha_pkg::QueueDepth
) (
	input  logic			clk,
	input  logic			arst_n,
	input  logic			wr_valid,
	output logic			wr_ready,
	input  sha_pkg::queue_item_t	wr_item,
	output logic			rd_valid,
	input  logic			rd_ready,
	output sha_pkg::queue_item_t	rd_item
);
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	sha_pkg::queue_item_t	mem_q [DEPTH];
	logic [AW-1:0]		wp_q, rp_q;
	logic [AW:0]		cnt_q;
	logic			wr_en, rd_en;

	assign wr_ready = (cnt_q != (AW+1)'(DEPTH));
	assign rd_valid = (cnt_q != '0);
	assign rd_item = mem_q[rp_q];
	assign wr_en = wr_valid && wr_ready;
	assign rd_en = rd_valid && rd_ready;

	always_ff @(posedge clk) begin
		if (wr_en) mem_q[wp_q] <= wr_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (wr_en) wp_q <= (wp_q == AW'(DEPTH - 1)) ? '0 : wp_q + AW'(1);
			if (rd_en) rp_q <= (rp_q == AW'(DEPTH - 1)) ? '0 : rp_q + AW'(1);
			cnt_q <= cnt_q + (AW+1)'(wr_en) - (AW+1)'(rd_en);
		end
	end
endmodule

/* rtl/sha_engine.sv */
// ----------------------------------------------------------------------------
// sha_engine
// schedule window load and 64-round compression, digest word output
// ----------------------------------------------------------------------------
module sha_engine (
	input  logic			clk,
	input  logic			arst_n,
	input  logic			q_valid,
	output logic			q_ready,
	input  sha_pkg::queue_item_t	q_item,
	sha_out_if.source		dout
);
	typedef enum logic [1:0] {ST_LOAD, ST_ROUND, ST_ADD, ST_EMIT} state_t;

	state_t		state_q;
	sha_pkg::hash_t	hv_q;
	sha_pkg::hash_t	r_q;		// a..h at index 0..7
	sha_pkg::word_t	w_q [16];
	logic [5:0]	t_q;
	logic		last_q;
	logic [2:0]	idx_q;
	logic		out_valid_q;
	sha_pkg::word_t	out_word_q;
	logic [2:0]	out_idx_q;
	logic		out_last_q;

	sha_pkg::word_t	w_new, w_cur, t1, t2, ch, maj;
	logic		out_free;

	// window kept as shift line: w_q[0] is w[t] for t < 16 and w[t-16] after that
	assign w_new = w_q[0] + sha_pkg::sig0(w_q[1]) + w_q[9] + sha_pkg::sig1(w_q[14]);
	assign w_cur = (t_q < 6'd16) ? w_q[0] : w_new;
	assign ch = (r_q[4] & r_q[5]) ^ (~r_q[4] & r_q[6]);
	assign maj = (r_q[0] & r_q[1]) ^ (r_q[0] & r_q[2]) ^ (r_q[1] & r_q[2]);
	assign t1 = r_q[7] + sha_pkg::bsig1(r_q[4]) + ch + sha_pkg::round_const(t_q) + w_cur;
	assign t2 = sha_pkg::bsig0(r_q[0]) + maj;

	assign q_ready = (state_q == ST_LOAD);
	assign out_free = !out_valid_q || dout.ready;
	assign dout.valid = out_valid_q;
	assign dout.digest_word = out_word_q;
	assign dout.word_index = out_idx_q;
	assign dout.last_word = out_last_q;

	always_ff @(posedge clk) begin
		if (state_q == ST_LOAD && q_valid) begin
			for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
			w_q[15] <= q_item.word;
		end else if (state_q == ST_ROUND) begin
			for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
			w_q[15] <= w_cur;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			hv_q <= sha_pkg::InitHash;
			r_q <= '0;
			t_q <= '0;
			last_q <= 1'b0;
			idx_q <= '0;
			out_valid_q <= 1'b0;
			out_word_q <= '0;
			out_idx_q <= '0;
			out_last_q <= 1'b0;
		end else begin
			// emit state refills the output register itself
			if (dout.ready && state_q != ST_EMIT) out_valid_q <= 1'b0;
			case (state_q)
				ST_LOAD: begin
					if (q_valid && q_item.blk_last) begin
						state_q <= ST_ROUND;
						last_q <= q_item.msg_last;
						r_q <= hv_q;
						t_q <= '0;
					end
				end
				ST_ROUND: begin
					r_q <= {r_q[6:4], r_q[3] + t1, r_q[2:0], t1 + t2};
					t_q <= t_q + 6'd1;
					if (t_q == 6'd63) state_q <= ST_ADD;
				end
				ST_ADD: begin
					for (int i = 0; i < 8; i++) hv_q[i] <= hv_q[i] + r_q[i];
					idx_q <= '0;
					state_q <= last_q ? ST_EMIT : ST_LOAD;
				end
				default: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_word_q <= hv_q[idx_q];
						out_idx_q <= idx_q;
						out_last_q <= (idx_q == 3'd7);
						idx_q <= idx_q + 3'd1;
						if (idx_q == 3'd7) begin
							hv_q <= sha_pkg::InitHash;
							state_q <= ST_LOAD;
						end
					end
				end
			endcase
		end
	end
endmodule

/* rtl/sha256_stream_hasher_core.sv */
// ----------------------------------------------------------------------------
// sha256_stream_hasher_core
// streaming sha-256 over a byte request channel
// ----------------------------------------------------------------------------
// Each byte request is taken while the front end is ready; it packs four bytes
// into a word and pushes it into a short queue. The compression engine pulls
// sixteen words (one per cycle while the queue holds words), runs 64 rounds one
// per cycle, then folds the result into the chaining value. While the rounds
// run, the four-word queue and the partial word hold only 19 bytes of the next
// block, so at one byte per cycle the rest of the block arrives while the
// engine loads; sustained throughput is set by the round loop and the queue
// depth. On end of message the front end emits the pad byte, zero words and
// the 64-bit bit length (one or two blocks), then the engine sends eight digest
// words, word 0 first, the last flagged, and restarts from the initial hash
// values.
// ----------------------------------------------------------------------------
module sha256_stream_hasher_core #(
	parameter int unsigned QUEUE_DEPTH = sha_pkg::QueueDepth
) (
	input  logic		clk,
	input  logic		arst_n,
	sha_in_if.sink		din,
	sha_out_if.source	dout
);
	// front end to queue
	logic			f_valid, f_ready;
	sha_pkg::queue_item_t	f_item;
	// queue to engine
	logic			e_valid, e_ready;
	sha_pkg::queue_item_t	e_item;

	sha_front u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(din.valid), .in_ready(din.ready),
		.has_byte(din.has_byte), .data_byte(din.data_byte),
		.end_of_message(din.end_of_message),
		.q_valid(f_valid), .q_ready(f_ready), .q_item(f_item)
	);

	sha_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
		.clk(clk), .arst_n(arst_n),
		.wr_valid(f_valid), .wr_ready(f_ready), .wr_item(f_item),
		.rd_valid(e_valid), .rd_ready(e_ready), .rd_item(e_item)
	);

	sha_engine u_engine (
		.clk(clk), .arst_n(arst_n),
		.q_valid(e_valid), .q_ready(e_ready), .q_item(e_item),
		.dout(dout)
	);
endmodule

/* rtl/sha_checker.sv */
// ----------------------------------------------------------------------------
// sha_checker
// port-level checks of the hasher output channel
// ----------------------------------------------------------------------------
module sha_checker (
	input  logic		clk,
	input  logic		arst_n,
	input  logic		out_valid,
	input  logic		out_ready,
	input  logic [31:0]	digest_word,
	input  logic [2:0]	word_index,
	input  logic		last_word
);
	// stalled word holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(digest_word))
		else $error("digest word changed under stall");

	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (last_word == (word_index == 3'd7)))
		else $error("last flag does not match word index");

	// words come in order within a digest
	a_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last_word |=>
		!out_valid || word_index == $past(word_index) + 3'd1)
		else $error("digest word out of order");
endmodule

bind sha256_stream_hasher_core sha_checker u_sha_checker (
	.clk(clk), .arst_n(arst_n),
	.out_valid(dout.valid), .out_ready(dout.ready),
	.digest_word(dout.digest_word), .word_index(dout.word_index),
	.last_word(dout.last_word)
);

/* sim/sha_digest_checker.sv */
// ----------------------------------------------------------------------------
// sha_digest_checker
// watches the byte and digest channels, predicts sha-256 digests, compares
// ----------------------------------------------------------------------------
module sha_digest_checker (
	input  logic	clk,
	input  logic	arst_n,
	sha_in_if	din,
	sha_out_if	dout,
	output int	fail_count,
	output int	pending_words
);
	typedef struct packed {
		sha_pkg::word_t	word;
		logic [2:0]	index;
		logic		last;
	} digest_entry_t;

	localparam sha_pkg::word_t RoundK [64] = '{
		32'h428A2F98, 32'h71374491, 32'hB5C0FBCF, 32'hE9B5DBA5, 32'h3956C25B, 32'h59F111F1,
		32'h923F82A4, 32'hAB1C5ED5, 32'hD807AA98, 32'h12835B01, 32'h243185BE, 32'h550C7DC3,
		32'h72BE5D74, 32'h80DEB1FE, 32'h9BDC06A7, 32'hC19BF174, 32'hE49B69C1, 32'hEFBE4786,
		32'h0FC19DC6, 32'h240CA1CC, 32'h2DE92C6F, 32'h4A7484AA, 32'h5CB0A9DC, 32'h76F988DA,
		32'h983E5152, 32'hA831C66D, 32'hB00327C8, 32'hBF597FC7, 32'hC6E00BF3, 32'hD5A79147,
		32'h06CA6351, 32'h14292967, 32'h27B70A85, 32'h2E1B2138, 32'h4D2C6DFC, 32'h53380D13,
		32'h650A7354, 32'h766A0ABB, 32'h81C2C92E, 32'h92722C85, 32'hA2BFE8A1, 32'hA81A664B,
		32'hC24B8B70, 32'hC76C51A3, 32'hD192E819, 32'hD6990624, 32'hF40E3585, 32'h106AA070,
		32'h19A4C116, 32'h1E376C08, 32'h2748774C, 32'h34B0BCB5, 32'h391C0CB3, 32'h4ED8AA4A,
		32'h5B9CCA4F, 32'h682E6FF3, 32'h748F82EE, 32'h78A5636F, 32'h84C87814, 32'h8CC70208,
		32'h90BEFFFA, 32'hA4506CEB, 32'hBEF9A3F7, 32'hC67178F2
	};
	localparam sha_pkg::word_t StartHash [8] = '{
		32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
		32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
	};

	sha_pkg::word_t	chain [8];
	logic [7:0]	blk [64];
	logic [5:0]	fill;
	logic [63:0]	bit_len;
	digest_entry_t	digest_q [$];

	function automatic sha_pkg::word_t ror32(sha_pkg::word_t x, int n);
		return (x >> n) | (x << (32 - n));
	endfunction

	task automatic compress_blk();
		sha_pkg::word_t w [64];
		sha_pkg::word_t v [8];
		sha_pkg::word_t t1, t2;
		for (int t = 0; t < 16; t++)
			w[t] = {blk[4*t], blk[4*t+1], blk[4*t+2], blk[4*t+3]};
		for (int t = 16; t < 64; t++)
			w[t] = w[t-16] + (ror32(w[t-15], 7) ^ ror32(w[t-15], 18) ^ (w[t-15] >> 3))
				+ w[t-7] + (ror32(w[t-2], 17) ^ ror32(w[t-2], 19) ^ (w[t-2] >> 10));
		v = chain;
		for (int t = 0; t < 64; t++) begin
			t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
				+ ((v[4] & v[5]) ^ (~v[4] & v[6])) + RoundK[t] + w[t];
			t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
				+ ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
			v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
			v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
		end
		for (int i = 0; i < 8; i++) chain[i] += v[i];
	endtask

	task automatic take_request(logic hb, logic [7:0] b, logic eom);
		int p;
		digest_entry_t ent;
		if (hb) begin
			blk[fill] = b;
			bit_len += 64'd8;
			if (fill == 6'd63) compress_blk();
			fill++;
		end
		if (eom) begin
			p = fill;
			blk[p++] = sha_pkg::PadByte;
			if (p > 56) begin
				while (p < 64) blk[p++] = 8'h00;
				compress_blk();
				p = 0;
			end
			while (p < 56) blk[p++] = 8'h00;
			for (int i = 0; i < 8; i++) blk[56+i] = bit_len[63-8*i -: 8];
			compress_blk();
			for (int k = 0; k < 8; k++) begin
				ent.word = chain[k];
				ent.index = 3'(k);
				ent.last = (k == 7);
				digest_q.insert(digest_q.size(), ent);
			end
			chain = StartHash;
			fill = '0;
			bit_len = '0;
		end
	endtask

	task automatic report(string what, sha_pkg::word_t got, sha_pkg::word_t want);
		$display("mismatch %s: got %h want %h at %0t", what, got, want, $time);
		fail_count++;
	endtask

	initial begin
		fail_count = 0;
		chain = StartHash;
		fill = '0;
		bit_len = '0;
	end

	assign pending_words = digest_q.size();

	always @(posedge clk) begin
		digest_entry_t e;
		if (arst_n) begin
			if (din.valid && din.ready)
				take_request(din.has_byte, din.data_byte, din.end_of_message);
			if (dout.valid && dout.ready) begin
				if (digest_q.size() == 0) begin
					report("unexpected word", dout.digest_word, '0);
				end else begin
					e = digest_q.pop_front();
					if (dout.digest_word !== e.word) report("digest_word", dout.digest_word, e.word);
					if (dout.word_index !== e.index) report("word_index", 32'(dout.word_index), 32'(e.index));
					if (dout.last_word !== e.last) report("last_word", 32'(dout.last_word), 32'(e.last));
				end
			end
		end
	end
endmodule

/* sim/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// byte stream stimulus for the sha-256 hasher with random idling and stalls
// ----------------------------------------------------------------------------
module testbench;
	logic	clk = 1'b0;
	logic	arst_n = 1'b0;
	int	fail_count;
	int	pending_words;
	int	cycle_count = 0;
	int	send_idle_pct = 0;	// sender gap chance per cycle
	int	recv_stall_pct = 0;	// receiver stall chance per cycle
	logic	hold_off = 1'b0;	// long receiver hold-off

	sha_in_if din ();
	sha_out_if dout ();

	sha256_stream_hasher_core i_dut (.clk(clk), .arst_n(arst_n), .din(din), .dout(dout));
	sha_digest_checker i_checker (.clk(clk), .arst_n(arst_n), .din(din), .dout(dout),
		.fail_count(fail_count), .pending_words(pending_words));

	always #5 clk = ~clk;

	// generous limit: ~230 requests, long messages, heavy stalls
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > 400000) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// receiver side: random stalls, or a long hold-off
	initial dout.ready = 1'b0;
	always @(negedge clk)
		dout.ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);

	// present one request and wait until it is accepted; valid stays up
	// for the next request unless an idle gap or drain drops it
	task automatic send_request(logic hb, logic [7:0] b, logic eom);
		while ($urandom_range(99) < send_idle_pct) begin
			din.valid <= 1'b0;
			@(negedge clk);
		end
		din.valid <= 1'b1;
		din.has_byte <= hb;
		din.data_byte <= b;
		din.end_of_message <= eom;
		@(posedge clk);
		while (!din.ready) @(posedge clk);
		@(negedge clk);
	endtask

	// a message of n bytes; the end flag rides on the last byte or alone
	task automatic send_message(int n, logic eom_alone);
		for (int i = 0; i < n; i++)
			send_request(1'b1, 8'($urandom), !eom_alone && i == n - 1);
		if (eom_alone || n == 0) send_request(1'b0, 8'($urandom), 1'b1);
	endtask

	task automatic drain();
		din.valid <= 1'b0;
		@(negedge clk);
		while (pending_words != 0) @(negedge clk);
	endtask

	initial begin
		din.valid = 1'b0;
		din.has_byte = 1'b0;
		din.data_byte = 8'h00;
		din.end_of_message = 1'b0;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;

		// empty message, byte extremes, end-only with a junk data byte
		send_request(1'b0, 8'hFF, 1'b1);
		send_request(1'b1, 8'h00, 1'b1);
		send_request(1'b1, 8'hFF, 1'b1);
		send_request(1'b0, 8'hA5, 1'b0);	// ignored byte mid-message
		send_request(1'b1, 8'h61, 1'b0);
		send_request(1'b1, 8'h62, 1'b0);
		send_request(1'b1, 8'h63, 1'b0);
		send_request(1'b0, 8'h5A, 1'b1);
		drain();

		// messages across padding boundaries (55, 56, 64 bytes) and a short one
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 52; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 52; end
				default: begin send_idle_pct = 37; recv_stall_pct = 37; end
			endcase
			send_message(ph == 0 ? 55 : ph == 1 ? 56 : ph == 2 ? 64 : 9, ph[0]);
			// random short messages, mostly well-formed
			repeat (2) begin
				if ($urandom_range(9) == 0) send_request(1'b0, 8'($urandom), 1'b0);
				send_message($urandom_range(6), $urandom_range(1));
			end
			if (ph == 1) begin
				// sender pauses until every digest word is back
				drain();
				// long receiver hold-off while the sender keeps pushing
				hold_off <= 1'b1;
				fork
					begin repeat (300) @(negedge clk); hold_off <= 1'b0; end
					begin
						send_message(12, 1'b0);
						send_message(3, 1'b0);
						send_message(0, 1'b1);
					end
				join
			end
		end
		send_idle_pct = 0;
		recv_stall_pct = 0;
		drain();
		repeat (200) @(negedge clk);
		if (fail_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end
endmodule
